@@ design/rlepd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlepd_pkg
// Shared types and constants of the run-length pixel row decoder.
// ----------------------------------------------------------------------------
package rlepd_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LEFT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_RIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_ROW    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_ENABLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_MODE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILL_SHIFT  = 3'd6;

  localparam int WIDTH_W  = 14;
  localparam int OFFSET_W = 15;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = 14'd8192;

  // remainder unit: one dividend bit a cycle
  localparam int REM_STEPS = OFFSET_W;
  localparam int REM_CNT_W = 4;

  localparam logic [6:0] RUN_MASK = 7'h7f;
  localparam int         REPEAT_BIT = 7;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_BYTE0  = 3'd1;
  localparam logic [2:0] PH_BYTE1  = 3'd2;
  localparam logic [2:0] PH_BYTE2  = 3'd3;
  localparam logic [2:0] PH_PIXEL  = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd7;

  typedef struct packed {
    logic       new_line;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic               span_valid;
    logic signed [15:0] span_first;
    logic signed [15:0] span_last;
    logic signed [15:0] span_row;
    logic        [23:0] span_color;
    logic        [7:0]  span_alpha;
    logic               span_blend;
    logic               pass_done;
    logic               replay_needed;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic row_start;
    logic div_start;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hold_valid;
    logic hold_new_line;
    logic draw_start;
    logic out_free;
    logic div_busy;
  } ctrl_sts_t;

endpackage
`default_nettype wire

@@ design/rlepd_rem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlepd_rem
// Restoring remainder unit: fill offset modulo map width, one bit a cycle.
// ----------------------------------------------------------------------------
module rlepd_rem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rlepd_pkg::OFFSET_W-1:0] dividend,
  input  wire logic [rlepd_pkg::WIDTH_W-1:0]  divisor,
  output logic                               busy,
  output logic [rlepd_pkg::WIDTH_W-1:0]      rem
);

  logic [rlepd_pkg::REM_CNT_W-1:0] cnt;
  logic [rlepd_pkg::OFFSET_W-1:0]  dvd;
  logic [rlepd_pkg::WIDTH_W-1:0]   dsr;
  logic [rlepd_pkg::WIDTH_W:0]     r_shift;
  logic [rlepd_pkg::WIDTH_W:0]     r_next;

  always_comb begin
    r_shift = {rem, dvd[rlepd_pkg::OFFSET_W-1]};
    if (r_shift >= {1'b0, dsr}) begin
      r_next = r_shift - {1'b0, dsr};
    end else begin
      r_next = r_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= rlepd_pkg::REM_CNT_W'(rlepd_pkg::REM_STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= r_next[rlepd_pkg::WIDTH_W-1:0];
      dvd <= {dvd[rlepd_pkg::OFFSET_W-2:0], 1'b0};
    end
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("remainder unit not busy after start");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dsr))
    else $error("partial remainder not below divisor");
`endif

endmodule
`default_nettype wire

@@ design/rlepd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlepd_ctrl
// Sequencer: issues a decode step per held beat, or runs the offset
// remainder first when a drawn row starts.
// ----------------------------------------------------------------------------
module rlepd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rlepd_pkg::ctrl_sts_t sts,
  output rlepd_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_RUN: begin
        if (sts.hold_valid) begin
          if (sts.hold_new_line && sts.draw_start) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end else if (sts.out_free) begin
            cmd.step      = 1'b1;
            cmd.row_start = sts.hold_new_line;
          end
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.step      = 1'b1;
          cmd.row_start = 1'b1;
          state_next    = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_div_enters: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == ST_DIV) && sts.div_busy)
    else $error("remainder not running after row start");
`endif

endmodule
`default_nettype wire

@@ design/rlepd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlepd_dp
// Datapath: configuration, input hold stage, run decode and span clipping,
// pass tracking and the result register.
// ----------------------------------------------------------------------------
module rlepd_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [rlepd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [rlepd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire rlepd_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output rlepd_pkg::out_item_t                     out_data,
  input  wire rlepd_pkg::ctrl_cmd_t                cmd,
  output rlepd_pkg::ctrl_sts_t                     sts,
  output logic                                     div_start,
  output logic [rlepd_pkg::OFFSET_W-1:0]           div_dividend,
  output logic [rlepd_pkg::WIDTH_W-1:0]            div_divisor,
  input  wire logic                                div_busy,
  input  wire logic [rlepd_pkg::WIDTH_W-1:0]       div_rem
);

  // configuration
  logic signed [15:0]                line_left;
  logic signed [15:0]                line_right;
  logic signed [15:0]                line_row;
  logic                              draw_enable;
  logic                              alpha_mode;
  logic [rlepd_pkg::WIDTH_W-1:0]     map_width;
  logic [rlepd_pkg::OFFSET_W-1:0]    fill_shift;

  // decode state
  logic [2:0]         byte_phase,   byte_phase_next;
  logic [7:0]         run_left,     run_left_next;
  logic               run_repeat,   run_repeat_next;
  logic [23:0]        color_gather, color_gather_next;
  logic signed [16:0] cur_x,        cur_x_next;
  logic signed [16:0] pass_origin,  pass_origin_next;
  logic               skipping,     skipping_next;

  logic                 hold_valid;
  rlepd_pkg::in_item_t  hold_item;
  rlepd_pkg::out_item_t res;

  logic [rlepd_pkg::WIDTH_W-1:0] eff_w;
  logic                          draw_start;
  logic                          out_free;

  // step operands after optional row start
  logic [2:0]         ph_e;
  logic [7:0]         rl_e;
  logic               rep_e;
  logic [23:0]        col_e;
  logic signed [16:0] cx_e;
  logic signed [16:0] org_e;
  logic               skip_e;

  logic [7:0]         b;
  logic [7:0]         n;
  logic signed [17:0] n18;
  logic signed [17:0] w18;
  logic signed [17:0] l18;
  logic signed [17:0] r18;
  logic signed [17:0] lo18;
  logic signed [17:0] hi18;
  logic signed [17:0] cx_adv;
  logic signed [17:0] org_adv;
  logic [7:0]         rl_dec;

  always_comb begin
    if (map_width == '0) begin
      eff_w = rlepd_pkg::WIDTH_W'(1);
    end else if (map_width > rlepd_pkg::MAX_WIDTH) begin
      eff_w = rlepd_pkg::MAX_WIDTH;
    end else begin
      eff_w = map_width;
    end
  end

  assign draw_start   = draw_enable && (line_left <= line_right);
  assign out_free     = !out_valid || out_ready;
  assign in_ready     = !hold_valid || cmd.step;
  assign div_start    = cmd.div_start;
  assign div_dividend = fill_shift;
  assign div_divisor  = eff_w;

  always_comb begin
    sts.hold_valid    = hold_valid;
    sts.hold_new_line = hold_item.new_line;
    sts.draw_start    = draw_start;
    sts.out_free      = out_free;
    sts.div_busy      = div_busy;
  end

  // operands: fresh row state or the stored one
  always_comb begin
    if (cmd.row_start) begin
      ph_e   = rlepd_pkg::PH_HEADER;
      rl_e   = '0;
      rep_e  = 1'b0;
      col_e  = '0;
      skip_e = !draw_start;
      if (draw_start) begin
        org_e = {line_left[15], line_left} - $signed({3'b000, div_rem});
      end else begin
        org_e = '0;
      end
      cx_e = org_e;
    end else begin
      ph_e   = byte_phase;
      rl_e   = run_left;
      rep_e  = run_repeat;
      col_e  = color_gather;
      skip_e = skipping;
      org_e  = pass_origin;
      cx_e   = cur_x;
    end
  end

  always_comb begin
    b       = hold_item.data_byte;
    n       = rep_e ? rl_e : 8'd1;
    n18     = $signed({10'd0, n});
    w18     = $signed({4'd0, eff_w});
    l18     = {{2{line_left[15]}}, line_left};
    r18     = {{2{line_right[15]}}, line_right};
    cx_adv  = {cx_e[16], cx_e} + n18;
    org_adv = {org_e[16], org_e} + w18;
    rl_dec  = rep_e ? 8'd0 : (rl_e - 8'd1);
    lo18    = ($signed({cx_e[16], cx_e}) < l18) ? l18 : $signed({cx_e[16], cx_e});
    hi18    = ((cx_adv - 18'sd1) > r18) ? r18 : (cx_adv - 18'sd1);

    byte_phase_next   = ph_e;
    run_left_next     = rl_e;
    run_repeat_next   = rep_e;
    color_gather_next = col_e;
    cur_x_next        = cx_e;
    pass_origin_next  = org_e;
    skipping_next     = skip_e;
    res               = '0;

    case (ph_e)
      rlepd_pkg::PH_HEADER: begin
        run_repeat_next   = b[rlepd_pkg::REPEAT_BIT];
        run_left_next     = {1'b0, b[6:0] & rlepd_pkg::RUN_MASK} + 8'd1;
        color_gather_next = '0;
        byte_phase_next   = rlepd_pkg::PH_BYTE0;
      end
      rlepd_pkg::PH_BYTE0: begin
        color_gather_next = col_e | {16'd0, b};
        byte_phase_next   = rlepd_pkg::PH_BYTE1;
      end
      rlepd_pkg::PH_BYTE1: begin
        color_gather_next = col_e | {8'd0, b, 8'd0};
        byte_phase_next   = rlepd_pkg::PH_BYTE2;
      end
      rlepd_pkg::PH_BYTE2: begin
        color_gather_next = col_e | {b, 16'd0};
        byte_phase_next   = rlepd_pkg::PH_PIXEL;
      end
      rlepd_pkg::PH_PIXEL: begin
        if (!skip_e && (lo18 <= hi18)) begin
          res.span_valid = 1'b1;
          res.span_first = lo18[15:0];
          res.span_last  = hi18[15:0];
          res.span_row   = line_row;
          res.span_color = col_e;
          if (alpha_mode) begin
            res.span_alpha = b;
            res.span_blend = 1'b1;
          end
        end
        cur_x_next    = cx_adv[16:0];
        run_left_next = rl_dec;
        if (rl_dec != 8'd0) begin
          byte_phase_next   = rlepd_pkg::PH_BYTE0;
          color_gather_next = '0;
        end else begin
          byte_phase_next = rlepd_pkg::PH_HEADER;
          if (cx_adv >= org_adv) begin
            res.pass_done = 1'b1;
            if (skip_e) begin
              byte_phase_next = rlepd_pkg::PH_DONE;
            end else begin
              pass_origin_next = org_adv[16:0];
              if (org_adv <= r18) begin
                res.replay_needed = 1'b1;
                cur_x_next        = org_adv[16:0];
              end else begin
                byte_phase_next = rlepd_pkg::PH_DONE;
              end
            end
          end
        end
      end
      default: begin
        // row finished: drop the beat
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_left   <= '0;
      line_right  <= '0;
      line_row    <= '0;
      draw_enable <= 1'b0;
      alpha_mode  <= 1'b0;
      map_width   <= rlepd_pkg::WIDTH_W'(1);
      fill_shift  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rlepd_pkg::CFG_LINE_LEFT:   line_left   <= cfg_data;
        rlepd_pkg::CFG_LINE_RIGHT:  line_right  <= cfg_data;
        rlepd_pkg::CFG_LINE_ROW:    line_row    <= cfg_data;
        rlepd_pkg::CFG_DRAW_ENABLE: draw_enable <= cfg_data[0];
        rlepd_pkg::CFG_ALPHA_MODE:  alpha_mode  <= cfg_data[0];
        rlepd_pkg::CFG_MAP_WIDTH:   map_width   <= cfg_data[rlepd_pkg::WIDTH_W-1:0];
        rlepd_pkg::CFG_FILL_SHIFT:  fill_shift  <= cfg_data[rlepd_pkg::OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= rlepd_pkg::PH_HEADER;
      run_left     <= '0;
      run_repeat   <= 1'b0;
      color_gather <= '0;
      cur_x        <= '0;
      pass_origin  <= '0;
      skipping     <= 1'b1;
    end else if (cmd.step) begin
      byte_phase   <= byte_phase_next;
      run_left     <= run_left_next;
      run_repeat   <= run_repeat_next;
      color_gather <= color_gather_next;
      cur_x        <= cur_x_next;
      pass_origin  <= pass_origin_next;
      skipping     <= skipping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (cmd.step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_step_room: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> hold_valid && out_free)
    else $error("decode step without held beat or result room");
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.span_valid) |-> (out_data.span_first <= out_data.span_last))
    else $error("span ends out of order");
`endif

endmodule
`default_nettype wire

@@ design/rle_pixelmap_row_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_pixelmap_row_decoder
// Run-length decoder for one 32bpp pixelmap row, giving clipped span commands.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one compressed byte a beat;
// new_line marks the first byte of a row. Every input beat yields exactly one
// result beat on out_valid/out_ready/out_data, in order.
// A beat is held in an input register and decoded from there into the
// result register once that is free, one beat a cycle sustained while the
// receiver keeps up and no drawn row start is running the remainder unit.
// A row-start beat with drawing on first runs the fill offset modulo map
// width through a bit-serial remainder unit, one offset bit a cycle,
// before the beat is decoded into the result register.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per cycle, only while no beat is in flight: a rule for the user, unchecked.
// Reset returns config and decode registers to defaults; the decoder consumes
// bytes as a non-drawing row at origin 0 until a new_line beat arrives.
// When the receiver stalls, the result register holds and one more input
// beat is taken into the input register; after that in_ready drops.
// ----------------------------------------------------------------------------
module rle_pixelmap_row_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rlepd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rlepd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rlepd_pkg::in_item_t               in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rlepd_pkg::out_item_t                   out_data
);

  rlepd_pkg::ctrl_cmd_t cmd;
  rlepd_pkg::ctrl_sts_t sts;

  logic                           div_start;
  logic [rlepd_pkg::OFFSET_W-1:0] div_dividend;
  logic [rlepd_pkg::WIDTH_W-1:0]  div_divisor;
  logic                           div_busy;
  logic [rlepd_pkg::WIDTH_W-1:0]  div_rem;

  rlepd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rlepd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cmd          (cmd),
    .sts          (sts),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_rem      (div_rem)
  );

  rlepd_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .rem      (div_rem)
  );

endmodule
`default_nettype wire

@@ dv/rle_pixelmap_row_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pixelmap_row_decoder_tb
// Self-checking bench for the run-length pixelmap row decoder. A short list
// of directed beats covers reset behaviour, register extremes, repeat and
// literal runs, a row cut by a new row and a row that is only consumed. It
// is followed by random rows that are replayed pass by pass as a feeder
// would, mixed with noise and cut rows. Every result beat is checked field
// by field against an in-bench decoder model or a pinned expected value,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module rle_pixelmap_row_decoder_tb;
  import rlepd_pkg::*;

  localparam int ROW_BEATS_TARGET = 450;
  localparam int TAIL_CYCLES      = 24;

  typedef logic [6:0][15:0] line_setup_t;

  typedef struct packed {
    bit          setup;
    line_setup_t vals;
    in_item_t    beat;
    bit          pinned;
    out_item_t   want;
  } plan_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;

  rle_pixelmap_row_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // decoder model: register copies
  logic [15:0]         reg_left   = '0;
  logic [15:0]         reg_right  = '0;
  logic [15:0]         reg_row    = '0;
  logic                reg_draw   = 1'b0;
  logic                reg_alpha  = 1'b0;
  logic [WIDTH_W-1:0]  reg_width  = 14'd1;
  logic [OFFSET_W-1:0] reg_offset = '0;

  // decoder model: row state
  logic [2:0]  dec_phase     = PH_HEADER;
  logic [7:0]  run_count     = '0;
  logic        run_is_repeat = 1'b0;
  logic [23:0] pix_color     = '0;
  int          pos_x         = 0;
  int          tile_origin   = 0;
  logic        consume_only  = 1'b1;

  out_item_t pending_spans[$];
  out_item_t last_pred;
  out_item_t want_span;
  plan_row_t plan[$];

  bit quiet_mode = 1'b0;
  int ready_hold = 0;
  int ready_draw;
  int fail_count = 0;
  int report_count = 0;
  int live_beats = 0;
  int row_count = 0;
  int setup_count = 0;
  int span_cmds = 0;
  int pass_ends = 0;
  int replays = 0;

  function automatic int gap_draw();
    if (quiet_mode) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic int tile_width();
    int w;
    w = reg_width;
    if (w == 0) w = 1;
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic out_item_t predict_span(input in_item_t beat);
    out_item_t r;
    int lft, rgt, w, n, lo, hi, sh;
    logic [7:0] b;
    r = '0;
    b = beat.data_byte;
    lft = $signed(reg_left);
    rgt = $signed(reg_right);
    w = tile_width();
    if (beat.new_line) begin
      dec_phase = PH_HEADER;
      run_count = '0;
      run_is_repeat = 1'b0;
      pix_color = '0;
      if (reg_draw && lft <= rgt) begin
        consume_only = 1'b0;
        tile_origin = lft - (int'(reg_offset) % w);
      end else begin
        consume_only = 1'b1;
        tile_origin = 0;
      end
      pos_x = tile_origin;
    end
    case (dec_phase)
      PH_HEADER: begin
        run_is_repeat = b[REPEAT_BIT];
        run_count = 8'(b[6:0] & RUN_MASK) + 8'd1;
        pix_color = '0;
        dec_phase = PH_BYTE0;
      end
      PH_BYTE0, PH_BYTE1, PH_BYTE2: begin
        sh = 8 * int'(dec_phase - PH_BYTE0);
        pix_color = pix_color | (24'(b) << sh);
        dec_phase = dec_phase + 3'd1;
      end
      PH_PIXEL: begin
        n = run_is_repeat ? int'(run_count) : 1;
        lo = pos_x;
        hi = pos_x + n - 1;
        if (!consume_only) begin
          if (lo < lft) lo = lft;
          if (hi > rgt) hi = rgt;
          if (lo <= hi) begin
            r.span_valid = 1'b1;
            r.span_first = lo[15:0];
            r.span_last  = hi[15:0];
            r.span_row   = reg_row;
            r.span_color = pix_color;
            if (reg_alpha) begin
              r.span_alpha = b;
              r.span_blend = 1'b1;
            end
          end
        end
        pos_x += n;
        if (run_is_repeat) run_count = '0;
        else run_count = run_count - 8'd1;
        if (run_count != 0) begin
          dec_phase = PH_BYTE0;
          pix_color = '0;
        end else begin
          dec_phase = PH_HEADER;
          if (pos_x >= tile_origin + w) begin
            r.pass_done = 1'b1;
            if (consume_only) begin
              dec_phase = PH_DONE;
            end else begin
              tile_origin += w;
              if (tile_origin <= rgt) begin
                r.replay_needed = 1'b1;
                pos_x = tile_origin;
              end else begin
                dec_phase = PH_DONE;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string span_text(input out_item_t s);
    return $sformatf("v=%0b x=%0d..%0d y=%0d rgb=%06h a=%02h bl=%0b pd=%0b rp=%0b",
                     s.span_valid, s.span_first, s.span_last, s.span_row, s.span_color,
                     s.span_alpha, s.span_blend, s.pass_done, s.replay_needed);
  endfunction

  function automatic void add_setup(input line_setup_t s);
    plan_row_t r;
    r = '0;
    r.setup = 1'b1;
    r.vals = s;
    plan.push_back(r);
  endfunction

  function automatic void add_beat(input bit nl, input logic [7:0] b,
                                   input bit pinned = 1'b0, input out_item_t want = '0);
    plan_row_t r;
    r = '0;
    r.beat.new_line = nl;
    r.beat.data_byte = b;
    r.pinned = pinned;
    r.want = want;
    plan.push_back(r);
  endfunction

  task automatic send_beat(input in_item_t beat, input bit pinned, input out_item_t want);
    int gap;
    out_item_t pred;
    gap = gap_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    if (!(dec_phase == PH_DONE && !beat.new_line)) live_beats++;
    pred = predict_span(beat);
    pending_spans.push_back(pinned ? want : pred);
    last_pred = pred;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_spans.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_LINE_LEFT:   reg_left = val;
      CFG_LINE_RIGHT:  reg_right = val;
      CFG_LINE_ROW:    reg_row = val;
      CFG_DRAW_ENABLE: reg_draw = val[0];
      CFG_ALPHA_MODE:  reg_alpha = val[0];
      CFG_MAP_WIDTH:   reg_width = val[WIDTH_W-1:0];
      CFG_FILL_SHIFT:  reg_offset = val[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_line(input line_setup_t s);
    drain();
    write_reg(CFG_LINE_LEFT, s[CFG_LINE_LEFT]);
    write_reg(CFG_LINE_RIGHT, s[CFG_LINE_RIGHT]);
    write_reg(CFG_LINE_ROW, s[CFG_LINE_ROW]);
    write_reg(CFG_DRAW_ENABLE, s[CFG_DRAW_ENABLE]);
    write_reg(CFG_ALPHA_MODE, s[CFG_ALPHA_MODE]);
    write_reg(CFG_MAP_WIDTH, s[CFG_MAP_WIDTH]);
    write_reg(CFG_FILL_SHIFT, s[CFG_FILL_SHIFT]);
    cfg_we <= 1'b0;
    setup_count++;
  endtask

  function automatic line_setup_t random_setup();
    line_setup_t s;
    int l, r;
    l = $urandom_range(0, 120) - 60;
    r = l + $urandom_range(0, 40);
    case ($urandom_range(0, 9))
      0: begin l = -32768; r = 32767; end
      1: r = l - $urandom_range(1, 20);
      2: begin l = $signed(16'($urandom)); r = $signed(16'($urandom)); end
      3: begin l = 32767; r = 32767; end
      4: begin l = -32768; r = -32768 + $urandom_range(0, 30); end
      default: ;
    endcase
    s[CFG_LINE_LEFT] = 16'(l);
    s[CFG_LINE_RIGHT] = 16'(r);
    s[CFG_LINE_ROW] = 16'($urandom);
    s[CFG_DRAW_ENABLE] = 16'($urandom_range(0, 4) != 0);
    s[CFG_ALPHA_MODE] = 16'($urandom_range(0, 1));
    case ($urandom_range(0, 11))
      0: s[CFG_MAP_WIDTH] = 16'd0;
      1: s[CFG_MAP_WIDTH] = 16'(MAX_WIDTH);
      2: s[CFG_MAP_WIDTH] = 16'h3fff;
      3: s[CFG_MAP_WIDTH] = 16'($urandom_range(1, 16383));
      default: s[CFG_MAP_WIDTH] = 16'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 3))
      0: s[CFG_FILL_SHIFT] = 16'h7fff;
      1: s[CFG_FILL_SHIFT] = 16'($urandom_range(0, 32767));
      default: s[CFG_FILL_SHIFT] = 16'($urandom_range(0, 30));
    endcase
    return s;
  endfunction

  task automatic send_row();
    logic [7:0] row_bytes[$];
    int remaining, n, cut, passes;
    in_item_t beat;
    remaining = (tile_width() <= 48) ? tile_width() : $urandom_range(8, 300);
    while (remaining > 0) begin
      if ($urandom_range(0, 1) == 1) begin
        n = $urandom_range(1, (remaining < 128) ? remaining : 128);
        row_bytes.push_back({1'b1, 7'(n - 1)});
        repeat (4) row_bytes.push_back(8'($urandom));
      end else begin
        n = $urandom_range(1, (remaining < 3) ? remaining : 3);
        row_bytes.push_back({1'b0, 7'(n - 1)});
        repeat (4 * n) row_bytes.push_back(8'($urandom));
      end
      remaining -= n;
    end
    // cut some rows short so the next row starts mid-run
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, row_bytes.size() - 1);
      repeat (cut) void'(row_bytes.pop_back());
    end
    row_count++;
    for (passes = 0; passes < 4; passes++) begin
      if (passes > 0 && $urandom_range(0, 7) == 0) begin
        drain();
        write_reg(CFG_LINE_ROW, 16'($urandom));
        write_reg(CFG_ALPHA_MODE, 16'($urandom_range(0, 1)));
        cfg_we <= 1'b0;
      end
      foreach (row_bytes[i]) begin
        beat.new_line = (passes == 0 && i == 0);
        beat.data_byte = row_bytes[i];
        send_beat(beat, 1'b0, '0);
      end
      if (!last_pred.replay_needed) break;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_valid && out_ready) begin
      ready_draw = gap_draw();
      ready_hold <= ready_draw;
      out_ready <= (ready_draw == 0);
    end else if (ready_hold > 1) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_hold <= 0;
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (out_data.span_valid) span_cmds++;
      if (out_data.pass_done) pass_ends++;
      if (out_data.replay_needed) replays++;
      if (pending_spans.size() == 0) begin
        fail_count++;
        if (report_count < 10) begin
          $display("%0t unexpected beat: %s", $realtime, span_text(out_data));
          report_count++;
        end
      end else begin
        want_span = pending_spans.pop_front();
        if (out_data.span_valid !== want_span.span_valid ||
            out_data.span_first !== want_span.span_first ||
            out_data.span_last !== want_span.span_last ||
            out_data.span_row !== want_span.span_row ||
            out_data.span_color !== want_span.span_color ||
            out_data.span_alpha !== want_span.span_alpha ||
            out_data.span_blend !== want_span.span_blend ||
            out_data.pass_done !== want_span.pass_done ||
            out_data.replay_needed !== want_span.replay_needed) begin
          fail_count++;
          if (report_count < 10) begin
            $display("%0t mismatch\n  expected %s\n  actual   %s", $realtime,
                     span_text(want_span), span_text(out_data));
            report_count++;
          end
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    line_setup_t s;
    out_item_t   pass_only;
    in_item_t    beat;
    int          k;

    pass_only = '0;
    pass_only.pass_done = 1'b1;

    // after reset: consume-only row at origin 0, then ignored
    add_beat(1'b0, 8'hff, 1'b1, '0);
    add_beat(1'b0, 8'haa, 1'b1, '0);
    add_beat(1'b0, 8'h55, 1'b1, '0);
    add_beat(1'b0, 8'h12, 1'b1, '0);
    add_beat(1'b0, 8'h34, 1'b1, pass_only);

    // widest clip window, zero width, largest offset
    s[CFG_LINE_LEFT] = 16'h8000;
    s[CFG_LINE_RIGHT] = 16'h7fff;
    s[CFG_LINE_ROW] = 16'h8000;
    s[CFG_DRAW_ENABLE] = 16'd1;
    s[CFG_ALPHA_MODE] = 16'd1;
    s[CFG_MAP_WIDTH] = 16'd0;
    s[CFG_FILL_SHIFT] = 16'h7fff;
    add_setup(s);
    add_beat(1'b1, 8'h81);
    add_beat(1'b0, 8'h00);
    add_beat(1'b0, 8'hff);
    add_beat(1'b0, 8'h80);
    add_beat(1'b0, 8'hff);
    add_beat(1'b0, 8'h01);
    add_beat(1'b0, 8'h01);
    add_beat(1'b0, 8'h02);
    add_beat(1'b0, 8'h03);
    add_beat(1'b0, 8'h00);
    add_beat(1'b0, 8'hff);
    add_beat(1'b0, 8'hfe);
    add_beat(1'b0, 8'hfd);
    add_beat(1'b0, 8'h7f);
    // new row arriving mid-run
    add_beat(1'b1, 8'hff);
    add_beat(1'b0, 8'h11);
    add_beat(1'b1, 8'h00);
    add_beat(1'b0, 8'h22);
    add_beat(1'b0, 8'h33);
    add_beat(1'b0, 8'h44);
    add_beat(1'b0, 8'h55);

    // left beyond right: row only consumed, then ignored
    s[CFG_LINE_LEFT] = 16'd5;
    s[CFG_LINE_RIGHT] = 16'd4;
    s[CFG_LINE_ROW] = 16'h1234;
    s[CFG_ALPHA_MODE] = 16'd0;
    s[CFG_MAP_WIDTH] = 16'd3;
    s[CFG_FILL_SHIFT] = 16'd0;
    add_setup(s);
    add_beat(1'b1, 8'h82);
    add_beat(1'b0, 8'h01);
    add_beat(1'b0, 8'h02);
    add_beat(1'b0, 8'h03);
    add_beat(1'b0, 8'h04, 1'b1, pass_only);
    add_beat(1'b0, 8'h80, 1'b1, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].setup) program_line(plan[i].vals);
      else send_beat(plan[i].beat, plan[i].pinned, plan[i].want);
    end

    live_beats = 0;
    program_line(random_setup());
    while (live_beats < ROW_BEATS_TARGET) begin
      if ($urandom_range(0, 2) == 0) program_line(random_setup());
      quiet_mode = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, 12);
        repeat (k) begin
          beat.new_line = ($urandom_range(0, 3) == 0);
          beat.data_byte = 8'($urandom);
          send_beat(beat, 1'b0, '0);
        end
      end else begin
        send_row();
      end
      // hold the sender until every result is back
      if ($urandom_range(0, 11) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d decoded beats over %0d rows and %0d register setups.",
             live_beats, row_count, setup_count);
    $display("Seen %0d span commands, %0d pass ends and %0d replay requests.",
             span_cmds, pass_ends, replays);
    if (fail_count == 0 && pending_spans.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
